>>> rtl/core/rtnfb_pkg.sv
// Shared types and constants for the radial/transverse/normal frame basis pipeline.
`default_nettype none

package rtnfb_pkg;

    // Pipeline geometry
    localparam int FRONT_STG = 5;                          // products, norms, undefined test
    localparam int DIV_STG   = 63;                         // quotient bits of a^2*2^62/S
    localparam int SQRT_STG  = 32;                         // root bits of the quotient
    localparam int UV_LAT    = DIV_STG + SQRT_STG + 1;     // unit vector lane latency
    localparam int TAIL_STG  = 3;                          // transverse products and rounding
    localparam int NSTG      = FRONT_STG + UV_LAT + TAIL_STG;

    // Datapath widths
    localparam int SQ_W   = 128;                           // squared magnitudes and norms
    localparam int Q_W    = DIV_STG;                       // quotient width
    localparam int SREM_W = DIV_STG + 1;                   // root remainder width
    localparam int ROOT_W = SQRT_STG;                      // root width

    typedef logic signed [31:0] q30_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [Q_W-1:0]     quo_t;
    typedef logic [SREM_W-1:0]  srem_t;
    typedef logic [ROOT_W-1:0]  root_t;

    localparam q30_t Q30_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } req_t;

    typedef struct packed {
        q30_t radial_x;
        q30_t radial_y;
        q30_t radial_z;
        q30_t along_x;
        q30_t along_y;
        q30_t along_z;
        q30_t normal_x;
        q30_t normal_y;
        q30_t normal_z;
        logic status;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/rtnfb_unit_vec.sv
// Unit vector lane: three rounded Q1.30 components a/sqrt(S) by pipelined division and root.
`default_nettype none

module rtnfb_unit_vec (
    input  logic             clk,
    input  logic             en,
    input  rtnfb_pkg::sq_t   sq [3],
    input  logic [2:0]       neg,
    input  rtnfb_pkg::sq_t   norm2,
    output rtnfb_pkg::q30_t  unit [3]
);

    localparam int DIV_STG  = rtnfb_pkg::DIV_STG;
    localparam int SQRT_STG = rtnfb_pkg::SQRT_STG;
    localparam int SQ_W     = rtnfb_pkg::SQ_W;
    localparam int Q_W      = rtnfb_pkg::Q_W;
    localparam int SREM_W   = rtnfb_pkg::SREM_W;
    localparam int ROOT_W   = rtnfb_pkg::ROOT_W;

    // Division stages: one quotient bit each
    rtnfb_pkg::sq_t  rem_reg  [1:DIV_STG][3];
    rtnfb_pkg::sq_t  rem_next [1:DIV_STG][3];
    rtnfb_pkg::quo_t quo_reg  [1:DIV_STG][3];
    rtnfb_pkg::quo_t quo_next [1:DIV_STG][3];
    rtnfb_pkg::sq_t  den_reg  [1:DIV_STG-1];
    rtnfb_pkg::sq_t  den_next [1:DIV_STG-1];
    logic [2:0]      dneg_reg  [1:DIV_STG];
    logic [2:0]      dneg_next [1:DIV_STG];

    // Root stages: one root bit each
    rtnfb_pkg::srem_t srem_reg  [1:SQRT_STG][3];
    rtnfb_pkg::srem_t srem_next [1:SQRT_STG][3];
    rtnfb_pkg::root_t root_reg  [1:SQRT_STG][3];
    rtnfb_pkg::root_t root_next [1:SQRT_STG][3];
    logic [2:0]       sneg_reg  [1:SQRT_STG];
    logic [2:0]       sneg_next [1:SQRT_STG];

    rtnfb_pkg::q30_t  unit_reg  [3];
    rtnfb_pkg::q30_t  unit_next [3];

    // Restoring division of a^2*2^62 by S; the first step sees the whole of a^2
    always_comb
    begin
        logic [SQ_W:0]   trial;
        rtnfb_pkg::sq_t  dv;
        rtnfb_pkg::quo_t qp;
        for (int k = 1; k <= DIV_STG; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (k == 1)
                begin
                    trial = {1'b0, sq[i]};
                    dv    = norm2;
                    qp    = '0;
                end
                else
                begin
                    trial = {rem_reg[k-1][i], 1'b0};
                    dv    = den_reg[k-1];
                    qp    = quo_reg[k-1][i];
                end
                if (trial >= {1'b0, dv})
                begin
                    rem_next[k][i] = SQ_W'(trial - {1'b0, dv});
                    quo_next[k][i] = {qp[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][i] = trial[SQ_W-1:0];
                    quo_next[k][i] = {qp[Q_W-2:0], 1'b0};
                end
            end
            if (k == 1)
                dneg_next[k] = neg;
            else
                dneg_next[k] = dneg_reg[k-1];
        end
        den_next[1] = norm2;
        for (int k = 2; k < DIV_STG; k++)
            den_next[k] = den_reg[k-1];
    end

    // Integer square root of the quotient, MSB first
    always_comb
    begin
        rtnfb_pkg::srem_t rm;
        rtnfb_pkg::srem_t cv;
        rtnfb_pkg::root_t rt;
        int               b;
        for (int j = 1; j <= SQRT_STG; j++)
        begin
            b = SQRT_STG - j;
            for (int i = 0; i < 3; i++)
            begin
                if (j == 1)
                begin
                    rm = {1'b0, quo_reg[DIV_STG][i]};
                    rt = '0;
                end
                else
                begin
                    rm = srem_reg[j-1][i];
                    rt = root_reg[j-1][i];
                end
                cv = (SREM_W'(rt) << (b + 1)) | (SREM_W'(1) << (2 * b));
                if (rm >= cv)
                begin
                    srem_next[j][i] = rm - cv;
                    root_next[j][i] = rt | (ROOT_W'(1) << b);
                end
                else
                begin
                    srem_next[j][i] = rm;
                    root_next[j][i] = rt;
                end
            end
            if (j == 1)
                sneg_next[j] = dneg_reg[DIV_STG];
            else
                sneg_next[j] = sneg_reg[j-1];
        end
    end

    // Largest odd d under the root gives m = (t+1)/2, then the sign
    always_comb
    begin
        logic [ROOT_W:0] mf;
        for (int i = 0; i < 3; i++)
        begin
            mf = {1'b0, root_reg[SQRT_STG][i]} + (ROOT_W+1)'(1);
            if (sneg_reg[SQRT_STG][i])
                unit_next[i] = -$signed(mf[ROOT_W:1]);
            else
                unit_next[i] = $signed(mf[ROOT_W:1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
            dneg_reg <= dneg_next;
            srem_reg <= srem_next;
            root_reg <= root_next;
            sneg_reg <= sneg_next;
            unit_reg <= unit_next;
        end
    end

    assign unit = unit_reg;

endmodule

`default_nettype wire

>>> rtl/core/rtn_orbit_frame_basis_top.sv
// Top level of the radial/transverse/normal orbit frame basis pipeline.
// One request (position and velocity, signed 32-bit) may enter every clock unless the
// output stalls, and one response leaves per request in order. The depth is set by the
// 63-step quotient a^2*2^62/S and the 32-step integer root in each unit vector lane;
// cross products and squared norms take five stages and the transverse row three more.
// A stalled output freezes the whole pipeline; status is 1 with all rows zero when |r|
// is zero or |r x v| <= 2^-40 |r||v|.
`default_nettype none

module rtn_orbit_frame_basis_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rtnfb_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rtnfb_pkg::rsp_t   rsp
);

    localparam int NSTG      = rtnfb_pkg::NSTG;
    localparam int FRONT_STG = rtnfb_pkg::FRONT_STG;
    localparam int SQ_W      = rtnfb_pkg::SQ_W;

    localparam logic signed [63:0] RND_POS = 64'sd536870912;
    localparam logic signed [63:0] RND_NEG = 64'sd536870911;

    // Valid line and global advance
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] vld_next;
    logic          adv;

    assign adv       = ~vld_reg[NSTG] | rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = vld_reg[NSTG];
    assign vld_next  = {vld_reg[NSTG-1:1], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Stage A: component products
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic signed [63:0] a_rsq_reg [3];
    logic signed [63:0] a_rsq_next [3];
    logic signed [63:0] a_vsq_reg [3];
    logic signed [63:0] a_vsq_next [3];
    logic signed [63:0] a_xp_reg [6];
    logic signed [63:0] a_xp_next [6];
    logic [2:0]         a_rneg_reg;
    logic [2:0]         a_rneg_next;

    always_comb
    begin
        pos[0] = req.pos_x;
        pos[1] = req.pos_y;
        pos[2] = req.pos_z;
        vel[0] = req.vel_x;
        vel[1] = req.vel_y;
        vel[2] = req.vel_z;
        for (int i = 0; i < 3; i++)
        begin
            a_rsq_next[i]  = 64'(pos[i]) * 64'(pos[i]);
            a_vsq_next[i]  = 64'(vel[i]) * 64'(vel[i]);
            a_rneg_next[i] = pos[i][31];
        end
        a_xp_next[0] = 64'(pos[1]) * 64'(vel[2]);
        a_xp_next[1] = 64'(pos[2]) * 64'(vel[1]);
        a_xp_next[2] = 64'(pos[2]) * 64'(vel[0]);
        a_xp_next[3] = 64'(pos[0]) * 64'(vel[2]);
        a_xp_next[4] = 64'(pos[0]) * 64'(vel[1]);
        a_xp_next[5] = 64'(pos[1]) * 64'(vel[0]);
    end

    // Stage B: squared norms and |r x v| components
    logic [63:0] b_rr_reg, b_rr_next;
    logic [63:0] b_vv_reg, b_vv_next;
    logic [63:0] b_rsq_reg [3];
    logic [63:0] b_rsq_next [3];
    logic [63:0] b_hmag_reg [3];
    logic [63:0] b_hmag_next [3];
    logic [2:0]  b_hneg_reg, b_hneg_next;
    logic [2:0]  b_rneg_reg, b_rneg_next;

    always_comb
    begin
        logic signed [63:0] h;
        b_rr_next   = 64'(a_rsq_reg[0]) + 64'(a_rsq_reg[1]) + 64'(a_rsq_reg[2]);
        b_vv_next   = 64'(a_vsq_reg[0]) + 64'(a_vsq_reg[1]) + 64'(a_vsq_reg[2]);
        b_rneg_next = a_rneg_reg;
        for (int i = 0; i < 3; i++)
        begin
            h              = a_xp_reg[2*i] - a_xp_reg[2*i+1];
            b_hneg_next[i] = h[63];
            b_hmag_next[i] = h[63] ? 64'(-h) : 64'(h);
            b_rsq_next[i]  = 64'(a_rsq_reg[i]);
        end
    end

    // Stage C: 32x32 partial products of |h|^2 and |r|^2|v|^2
    logic [63:0] c_hhh_reg [3];
    logic [63:0] c_hhh_next [3];
    logic [63:0] c_hhl_reg [3];
    logic [63:0] c_hhl_next [3];
    logic [63:0] c_hll_reg [3];
    logic [63:0] c_hll_next [3];
    logic [63:0] c_rv11_reg, c_rv11_next;
    logic [63:0] c_rv10_reg, c_rv10_next;
    logic [63:0] c_rv01_reg, c_rv01_next;
    logic [63:0] c_rv00_reg, c_rv00_next;
    logic [63:0] c_rr_reg, c_rr_next;
    logic [63:0] c_rsq_reg [3];
    logic [63:0] c_rsq_next [3];
    logic [2:0]  c_hneg_reg, c_hneg_next;
    logic [2:0]  c_rneg_reg, c_rneg_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_hhh_next[i] = 64'(b_hmag_reg[i][63:32]) * 64'(b_hmag_reg[i][63:32]);
            c_hhl_next[i] = 64'(b_hmag_reg[i][63:32]) * 64'(b_hmag_reg[i][31:0]);
            c_hll_next[i] = 64'(b_hmag_reg[i][31:0]) * 64'(b_hmag_reg[i][31:0]);
            c_rsq_next[i] = b_rsq_reg[i];
        end
        c_rv11_next = 64'(b_rr_reg[63:32]) * 64'(b_vv_reg[63:32]);
        c_rv10_next = 64'(b_rr_reg[63:32]) * 64'(b_vv_reg[31:0]);
        c_rv01_next = 64'(b_rr_reg[31:0]) * 64'(b_vv_reg[63:32]);
        c_rv00_next = 64'(b_rr_reg[31:0]) * 64'(b_vv_reg[31:0]);
        c_rr_next   = b_rr_reg;
        c_hneg_next = b_hneg_reg;
        c_rneg_next = b_rneg_reg;
    end

    // Stage D: assemble 128-bit squares
    rtnfb_pkg::sq_t d_hsq_reg [3];
    rtnfb_pkg::sq_t d_hsq_next [3];
    rtnfb_pkg::sq_t d_rv_reg, d_rv_next;
    logic [63:0]    d_rr_reg, d_rr_next;
    logic [63:0]    d_rsq_reg [3];
    logic [63:0]    d_rsq_next [3];
    logic [2:0]     d_hneg_reg, d_hneg_next;
    logic [2:0]     d_rneg_reg, d_rneg_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_hsq_next[i] = {c_hhh_reg[i], c_hll_reg[i]} + (SQ_W'(c_hhl_reg[i]) << 33);
            d_rsq_next[i] = c_rsq_reg[i];
        end
        d_rv_next   = {c_rv11_reg, c_rv00_reg} + (SQ_W'(c_rv10_reg) << 32)
                    + (SQ_W'(c_rv01_reg) << 32);
        d_rr_next   = c_rr_reg;
        d_hneg_next = c_hneg_reg;
        d_rneg_next = c_rneg_reg;
    end

    // Stage E: |r x v|^2
    rtnfb_pkg::sq_t e_hh_reg, e_hh_next;
    rtnfb_pkg::sq_t e_hsq_reg [3];
    rtnfb_pkg::sq_t e_rv_reg, e_rv_next;
    logic [63:0]    e_rr_reg, e_rr_next;
    logic [63:0]    e_rsq_reg [3];
    logic [2:0]     e_hneg_reg, e_hneg_next;
    logic [2:0]     e_rneg_reg, e_rneg_next;

    always_comb
    begin
        e_hh_next   = d_hsq_reg[0] + d_hsq_reg[1] + d_hsq_reg[2];
        e_rv_next   = d_rv_reg;
        e_rr_next   = d_rr_reg;
        e_hneg_next = d_hneg_reg;
        e_rneg_next = d_rneg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_rsq_reg  <= a_rsq_next;
            a_vsq_reg  <= a_vsq_next;
            a_xp_reg   <= a_xp_next;
            a_rneg_reg <= a_rneg_next;
            b_rr_reg   <= b_rr_next;
            b_vv_reg   <= b_vv_next;
            b_rsq_reg  <= b_rsq_next;
            b_hmag_reg <= b_hmag_next;
            b_hneg_reg <= b_hneg_next;
            b_rneg_reg <= b_rneg_next;
            c_hhh_reg  <= c_hhh_next;
            c_hhl_reg  <= c_hhl_next;
            c_hll_reg  <= c_hll_next;
            c_rv11_reg <= c_rv11_next;
            c_rv10_reg <= c_rv10_next;
            c_rv01_reg <= c_rv01_next;
            c_rv00_reg <= c_rv00_next;
            c_rr_reg   <= c_rr_next;
            c_rsq_reg  <= c_rsq_next;
            c_hneg_reg <= c_hneg_next;
            c_rneg_reg <= c_rneg_next;
            d_hsq_reg  <= d_hsq_next;
            d_rv_reg   <= d_rv_next;
            d_rr_reg   <= d_rr_next;
            d_rsq_reg  <= d_rsq_next;
            d_hneg_reg <= d_hneg_next;
            d_rneg_reg <= d_rneg_next;
            e_hh_reg   <= e_hh_next;
            e_hsq_reg  <= d_hsq_reg;
            e_rv_reg   <= e_rv_next;
            e_rr_reg   <= e_rr_next;
            e_rsq_reg  <= d_rsq_reg;
            e_hneg_reg <= e_hneg_next;
            e_rneg_reg <= e_rneg_next;
        end
    end

    // Undefined basis flag, carried alongside the unit vector lanes
    logic [NSTG-1:FRONT_STG+1] und_reg;
    logic [NSTG-1:FRONT_STG+1] und_next;
    logic                      und_e;

    assign und_e    = (e_rr_reg == '0)
                    | ((e_hh_reg[SQ_W-1:48] == '0) & (e_hh_reg[47:0] <= e_rv_reg[SQ_W-1:80]));
    assign und_next = {und_reg[NSTG-2:FRONT_STG+1], und_e};

    always_ff @(posedge clk)
    begin
        if (adv)
            und_reg <= und_next;
    end

    // Radial and normal unit vector lanes
    rtnfb_pkg::sq_t  rad_sq [3];
    rtnfb_pkg::sq_t  rad_norm2;
    rtnfb_pkg::q30_t er [3];
    rtnfb_pkg::q30_t en [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rad_sq[i] = SQ_W'(e_rsq_reg[i]);
        rad_norm2 = SQ_W'(e_rr_reg);
    end

    rtnfb_unit_vec u_radial (
        .clk   (clk),
        .en    (adv),
        .sq    (rad_sq),
        .neg   (e_rneg_reg),
        .norm2 (rad_norm2),
        .unit  (er)
    );

    rtnfb_unit_vec u_normal (
        .clk   (clk),
        .en    (adv),
        .sq    (e_hsq_reg),
        .neg   (e_hneg_reg),
        .norm2 (e_hh_reg),
        .unit  (en)
    );

    // Tail stage 1: normal x radial products
    logic signed [63:0] t1_p_reg [3];
    logic signed [63:0] t1_p_next [3];
    logic signed [63:0] t1_q_reg [3];
    logic signed [63:0] t1_q_next [3];
    rtnfb_pkg::q30_t    t1_er_reg [3];
    rtnfb_pkg::q30_t    t1_en_reg [3];

    always_comb
    begin
        t1_p_next[0] = 64'(en[1]) * 64'(er[2]);
        t1_q_next[0] = 64'(en[2]) * 64'(er[1]);
        t1_p_next[1] = 64'(en[2]) * 64'(er[0]);
        t1_q_next[1] = 64'(en[0]) * 64'(er[2]);
        t1_p_next[2] = 64'(en[0]) * 64'(er[1]);
        t1_q_next[2] = 64'(en[1]) * 64'(er[0]);
    end

    // Tail stage 2: differences in Q2.60
    logic signed [63:0] t2_d_reg [3];
    logic signed [63:0] t2_d_next [3];
    rtnfb_pkg::q30_t    t2_er_reg [3];
    rtnfb_pkg::q30_t    t2_en_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            t2_d_next[i] = t1_p_reg[i] - t1_q_reg[i];
    end

    // Tail stage 3: round to Q1.30, saturate, mask on undefined basis
    rtnfb_pkg::rsp_t rsp_reg, rsp_next;
    rtnfb_pkg::q30_t et [3];

    always_comb
    begin
        logic signed [63:0] rnd;
        logic signed [63:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            rnd = t2_d_reg[i] + (t2_d_reg[i][63] ? RND_NEG : RND_POS);
            sh  = rnd >>> 30;
            if (sh > 64'(rtnfb_pkg::Q30_ONE))
                et[i] = rtnfb_pkg::Q30_ONE;
            else if (sh < -64'(rtnfb_pkg::Q30_ONE))
                et[i] = -rtnfb_pkg::Q30_ONE;
            else
                et[i] = sh[31:0];
        end
        if (und_reg[NSTG-1])
        begin
            rsp_next        = '0;
            rsp_next.status = 1'b1;
        end
        else
        begin
            rsp_next.radial_x = t2_er_reg[0];
            rsp_next.radial_y = t2_er_reg[1];
            rsp_next.radial_z = t2_er_reg[2];
            rsp_next.along_x  = et[0];
            rsp_next.along_y  = et[1];
            rsp_next.along_z  = et[2];
            rsp_next.normal_x = t2_en_reg[0];
            rsp_next.normal_y = t2_en_reg[1];
            rsp_next.normal_z = t2_en_reg[2];
            rsp_next.status   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_p_reg  <= t1_p_next;
            t1_q_reg  <= t1_q_next;
            t1_er_reg <= er;
            t1_en_reg <= en;
            t2_d_reg  <= t2_d_next;
            t2_er_reg <= t1_er_reg;
            t2_en_reg <= t1_en_reg;
            rsp_reg   <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    // Checks
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid line moved during a stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> vld_reg[1])
        else $error("accepted request did not enter the first stage");

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |->
            (rsp.radial_x == 0 && rsp.radial_y == 0 && rsp.radial_z == 0 &&
             rsp.along_x == 0 && rsp.along_y == 0 && rsp.along_z == 0 &&
             rsp.normal_x == 0 && rsp.normal_y == 0 && rsp.normal_z == 0))
        else $error("undefined basis with non-zero rows");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.status |->
            (rsp.along_x <= rtnfb_pkg::Q30_ONE && rsp.along_x >= -rtnfb_pkg::Q30_ONE &&
             rsp.along_y <= rtnfb_pkg::Q30_ONE && rsp.along_y >= -rtnfb_pkg::Q30_ONE &&
             rsp.along_z <= rtnfb_pkg::Q30_ONE && rsp.along_z >= -rtnfb_pkg::Q30_ONE))
        else $error("transverse component outside unit range");

endmodule

`default_nettype wire

>>> sim/rtn_orbit_frame_basis_top_tb.sv
// Self-checking testbench for the radial/transverse/normal orbit frame basis pipeline.
`default_nettype none

module rtn_orbit_frame_basis_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYC = rtnfb_pkg::NSTG + 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    rtnfb_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rtnfb_pkg::rsp_t rsp;

    rtnfb_pkg::rsp_t frame_q[$];
    int   mismatches = 0;
    int   reqs_sent = 0;
    int   frames_seen = 0;
    int   undef_seen = 0;
    bit   steady = 1'b0;       // no idling on either side while set

    rtn_orbit_frame_basis_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // round(a * 2^30 / sqrt(s)), ties away from zero, by bisection on the exact test
    function automatic rtnfb_pkg::q30_t unit_q30(logic signed [65:0] a, logic [255:0] s);
        logic [65:0]  am;
        logic [255:0] target;
        logic [255:0] d;
        longint       lo;
        longint       hi;
        longint       mid;
        am = (a < 0) ? -a : a;
        target = ({190'd0, am} * {190'd0, am}) << 62;
        lo = 0;
        hi = 64'sd1 << 30;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >>> 1;
            d = 256'(2 * mid - 1);
            if (s * d * d <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (a < 0) ? rtnfb_pkg::q30_t'(-lo) : rtnfb_pkg::q30_t'(lo);
    endfunction

    // (p - q) >> 30 rounded, ties away from zero, magnitude capped at 2^30
    function automatic rtnfb_pkg::q30_t q60_round(longint p, longint q);
        longint d;
        longint m;
        d = p - q;
        m = (((d < 0) ? -d : d) + (64'sd1 << 29)) >>> 30;
        if (m > (64'sd1 << 30))
            m = 64'sd1 << 30;
        return (d < 0) ? rtnfb_pkg::q30_t'(-m) : rtnfb_pkg::q30_t'(m);
    endfunction

    // Expected frame for one request
    function automatic rtnfb_pkg::rsp_t frame_of(rtnfb_pkg::req_t q);
        logic signed [65:0] r [3];
        logic signed [65:0] v [3];
        logic signed [65:0] h [3];
        logic [65:0]        m;
        logic [255:0]       rr;
        logic [255:0]       vv;
        logic [255:0]       hh;
        longint             er [3];
        longint             en [3];
        rtnfb_pkg::rsp_t    f;
        r[0] = q.pos_x; r[1] = q.pos_y; r[2] = q.pos_z;
        v[0] = q.vel_x; v[1] = q.vel_y; v[2] = q.vel_z;
        h[0] = r[1] * v[2] - r[2] * v[1];
        h[1] = r[2] * v[0] - r[0] * v[2];
        h[2] = r[0] * v[1] - r[1] * v[0];
        rr = '0; vv = '0; hh = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = (r[i] < 0) ? -r[i] : r[i];
            rr += {190'd0, m} * {190'd0, m};
            m = (v[i] < 0) ? -v[i] : v[i];
            vv += {190'd0, m} * {190'd0, m};
            m = (h[i] < 0) ? -h[i] : h[i];
            hh += {190'd0, m} * {190'd0, m};
        end
        f = '0;
        if (rr == 0 || (hh << 80) <= rr * vv)
        begin
            f.status = 1'b1;
            return f;
        end
        for (int i = 0; i < 3; i++)
        begin
            er[i] = unit_q30(r[i], rr);
            en[i] = unit_q30(h[i], hh);
        end
        f.radial_x = rtnfb_pkg::q30_t'(er[0]);
        f.radial_y = rtnfb_pkg::q30_t'(er[1]);
        f.radial_z = rtnfb_pkg::q30_t'(er[2]);
        f.normal_x = rtnfb_pkg::q30_t'(en[0]);
        f.normal_y = rtnfb_pkg::q30_t'(en[1]);
        f.normal_z = rtnfb_pkg::q30_t'(en[2]);
        f.along_x  = q60_round(en[1] * er[2], en[2] * er[1]);
        f.along_y  = q60_round(en[2] * er[0], en[0] * er[2]);
        f.along_z  = q60_round(en[0] * er[1], en[1] * er[0]);
        return f;
    endfunction

    // Send one request, with an optional idle gap first
    task automatic send_req(rtnfb_pkg::req_t q);
        if (!steady && $urandom_range(99) < 36)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 36)
                @(posedge clk);
        end
        req <= q;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        frame_q.push_back(frame_of(q));
        reqs_sent++;
    endtask

    task automatic send_vec(int px, int py, int pz, int vx, int vy, int vz);
        rtnfb_pkg::req_t q;
        q.pos_x = px; q.pos_y = py; q.pos_z = pz;
        q.vel_x = vx; q.vel_y = vy; q.vel_z = vz;
        send_req(q);
    endtask

    // Sink readiness
    always @(posedge clk)
        rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 36);

    task automatic check_field(string name, rtnfb_pkg::q30_t exp_v, rtnfb_pkg::q30_t act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d", name, exp_v, act_v);
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin
        rtnfb_pkg::rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (frame_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response with nothing outstanding");
            end
            else
            begin
                e = frame_q.pop_front();
                frames_seen++;
                if (e.status)
                    undef_seen++;
                check_field("radial_x", e.radial_x, rsp.radial_x);
                check_field("radial_y", e.radial_y, rsp.radial_y);
                check_field("radial_z", e.radial_z, rsp.radial_z);
                check_field("along_x", e.along_x, rsp.along_x);
                check_field("along_y", e.along_y, rsp.along_y);
                check_field("along_z", e.along_z, rsp.along_z);
                check_field("normal_x", e.normal_x, rsp.normal_x);
                check_field("normal_y", e.normal_y, rsp.normal_y);
                check_field("normal_z", e.normal_z, rsp.normal_z);
                if (e.status !== rsp.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch status: expected %0d got %0d", e.status, rsp.status);
                end
            end
        end
    end

    localparam int MAXP = 32'sh7fff_ffff;
    localparam int MINN = 32'sh8000_0000;

    // Extremes, degenerate inputs and hand-picked geometries
    task automatic test_directed();
        send_vec(0, 0, 0, 0, 0, 0);
        send_vec(0, 0, 0, 5, -7, 9);
        send_vec(1000, 2000, 3000, 0, 0, 0);
        send_vec(3, 4, 0, 6, 8, 0);
        send_vec(3, 4, 0, -6, -8, 0);
        send_vec(1, 0, 0, 0, 1, 0);
        send_vec(0, 1, 0, 0, 0, 1);
        send_vec(0, 0, -1, -1, 0, 0);
        send_vec(MINN, MINN, MINN, MINN, MINN, MINN);
        send_vec(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP);
        send_vec(MINN, 0, 0, 0, MAXP, 0);
        send_vec(MAXP, MINN, MAXP, MINN, MAXP, 0);
        send_vec(MINN, MAXP, MINN, MAXP, MAXP, MINN);
        send_vec(-1, -1, -1, 1, -1, 1);
        // cross product of 1 against huge norms: below the undefined-basis threshold
        send_vec(MAXP, MAXP - 1, 0, MAXP - 1, MAXP - 2, 0);
        send_vec(1 << 20, (1 << 20) - 1, 0, (1 << 20) - 1, (1 << 20) - 2, 0);
        send_vec(1, 1, 1, 1, 1, 2);
        send_vec(7000000, 0, 0, 0, 7500, 1);
        send_vec(-6378137, 12, 4, 3, -7800, 60);
        send_vec(MAXP, 0, 0, MAXP, 1, 0);
    endtask

    function automatic int pick_edge();
        case ($urandom_range(5))
            0: return MINN;
            1: return MAXP;
            2: return 0;
            3: return 1;
            4: return -1;
            default: return int'($urandom);
        endcase
    endfunction

    // Random mix of general, small, parallel, near-parallel and edge vectors
    task automatic test_random(int n);
        rtnfb_pkg::req_t q;
        int   k;
        int   a;
        int   b;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 40)
                q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            else if (k < 60)
            begin
                q.pos_x = int'($urandom_range(200)) - 100;
                q.pos_y = int'($urandom_range(200)) - 100;
                q.pos_z = int'($urandom_range(200)) - 100;
                q.vel_x = int'($urandom_range(200)) - 100;
                q.vel_y = int'($urandom_range(200)) - 100;
                q.vel_z = int'($urandom_range(200)) - 100;
            end
            else if (k < 75)
            begin
                a = int'($urandom_range(2000)) - 1000;
                q.pos_x = int'($urandom_range(20000)) - 10000;
                q.pos_y = int'($urandom_range(20000)) - 10000;
                q.pos_z = int'($urandom_range(20000)) - 10000;
                q.vel_x = q.pos_x * a;
                q.vel_y = q.pos_y * a;
                q.vel_z = q.pos_z * a;
            end
            else if (k < 90)
            begin
                a = int'($urandom_range(32'h7fff_fff0, 2));
                b = int'($urandom);
                if ($urandom_range(1))
                    a = -a;
                q.pos_x = a; q.pos_y = a - 1; q.pos_z = b;
                q.vel_x = a - 1; q.vel_y = a - 2; q.vel_z = b;
            end
            else
            begin
                q.pos_x = pick_edge(); q.pos_y = pick_edge(); q.pos_z = pick_edge();
                q.vel_x = pick_edge(); q.vel_y = pick_edge(); q.vel_z = pick_edge();
            end
            send_req(q);
        end
    endtask

    // Back-to-back stretch with both sides always ready
    task automatic test_full_rate(int n);
        steady = 1'b1;
        test_random(n);
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_full_rate(300);
        test_random(500);
        req_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        $display("Run covered %0d requests, %0d responses checked, %0d undefined bases.",
                 reqs_sent, frames_seen, undef_seen);
        $display("Inputs: extremes, degenerate, parallel, near-parallel and random vectors.");
        if (mismatches == 0 && frame_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/rtnfb_pkg.sv
rtl/core/rtnfb_unit_vec.sv
rtl/core/rtn_orbit_frame_basis_top.sv
sim/rtn_orbit_frame_basis_top_tb.sv
